/* rtl/core/sha1_pkg.sv */
package sha1_pkg;

  localparam int unsigned NumWords  = 5;
  localparam int unsigned WinWords  = 16;
  localparam int unsigned BlkBytes  = 64;

  localparam logic [6:0] RoundLast = 7'd79;
  localparam logic [5:0] LenPos    = 6'd56;
  localparam logic [5:0] BlkLast   = 6'd63;
  localparam logic [2:0] WordLast  = 3'd4;
  localparam logic [7:0] PadByte   = 8'h80;

  localparam logic [31:0] H0Init = 32'h67452301;
  localparam logic [31:0] H1Init = 32'hEFCDAB89;
  localparam logic [31:0] H2Init = 32'h98BADCFE;
  localparam logic [31:0] H3Init = 32'h10325476;
  localparam logic [31:0] H4Init = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } sha1_state_e;

  typedef enum logic [1:0] {
    AFT_IDLE,
    AFT_PAD,
    AFT_EMIT
  } sha1_after_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } dig_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  // byte write port and window shift between sequencer and schedule
  typedef struct packed {
    logic       wr_en;
    logic [5:0] wr_idx;
    logic [7:0] wr_byte;
    logic       shift;
  } sched_ctrl_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

endpackage

/* rtl/core/sha1_stream_if.sv */
interface sha1_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/sha1_hash_engine_core.sv */
// SHA-1 engine taking one message byte per request and returning the digest as
// five 32-bit big-endian words, h0 first, the fifth flagged last. A request with
// byte_valid low and end_of_message high ends the message without a byte (an
// empty message this way gives the empty-string digest); a request with both
// low is dropped. Every 64th byte starts a compression (80 rounds through a
// single round unit, then one fold) during which no request is taken. At end
// of message the padding bytes are written one per cycle up to the end of the
// block and that block is compressed; when the length does not fit, a second
// block of 64 padding writes and one more compression follow. The digest is
// then sent as five words, each held while the sink stalls. Afterwards the
// chaining words and byte count return to their initial values for the next
// message.
module sha1_hash_engine_core
  import sha1_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  sha1_stream_if.sink   req_i,
  sha1_stream_if.source dig_o
);

  sha1_state_e state_q, state_d;
  sha1_after_e after_q, after_d;

  logic [31:0] h_q [NumWords];
  logic [31:0] h_d [NumWords];
  work_t       work_q, work_d, work_rnd;
  logic [60:0] count_q, count_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [5:0]  pad_pos_q, pad_pos_d;
  logic        pad_first_q, pad_first_d;
  logic        len_blk_q, len_blk_d;
  logic [2:0]  idx_q, idx_d;

  sched_ctrl_t ctrl;
  logic [31:0] w;
  logic [63:0] len_bits;
  logic        req_acc;
  logic        dig_acc;
  logic        blk_full;
  logic        len_here;

  sha1_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .w_o    (w)
  );

  sha1_round u_round (
    .work_i (work_q),
    .w_i    (w),
    .rnd_i  (rnd_q),
    .work_o (work_rnd)
  );

  assign req_acc  = req_i.valid && req_i.ready;
  assign dig_acc  = dig_o.valid && dig_o.ready;
  assign blk_full = req_i.payload.byte_valid && (count_q[5:0] == BlkLast);
  assign len_bits = {count_q, 3'b000};
  // does this padding block carry the length field
  assign len_here = pad_first_q ? (pad_pos_q < LenPos) : len_blk_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          if (blk_full) begin
            state_d = ST_ROUND;
          end else if (req_i.payload.end_of_message) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (rnd_q == RoundLast) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        unique case (after_q)
          AFT_PAD:  state_d = ST_PAD;
          AFT_EMIT: state_d = ST_EMIT;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_PAD: begin
        if (pad_pos_q == BlkLast) begin
          state_d = ST_ROUND;
        end
      end
      ST_EMIT: begin
        if (dig_acc && idx_q == WordLast) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    after_d     = after_q;
    h_d         = h_q;
    work_d      = work_q;
    count_d     = count_q;
    rnd_d       = rnd_q;
    pad_pos_d   = pad_pos_q;
    pad_first_d = pad_first_q;
    len_blk_d   = len_blk_q;
    idx_d       = idx_q;
    ctrl        = '0;

    req_i.ready               = (state_q == ST_IDLE);
    dig_o.valid               = (state_q == ST_EMIT);
    dig_o.payload.digest_last = (idx_q == WordLast);
    case (idx_q)
      3'd0:    dig_o.payload.digest_word = h_q[0];
      3'd1:    dig_o.payload.digest_word = h_q[1];
      3'd2:    dig_o.payload.digest_word = h_q[2];
      3'd3:    dig_o.payload.digest_word = h_q[3];
      default: dig_o.payload.digest_word = h_q[4];
    endcase

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          if (req_i.payload.byte_valid) begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_idx  = count_q[5:0];
            ctrl.wr_byte = req_i.payload.data_byte;
            count_d      = count_q + 61'd1;
          end
          pad_first_d = 1'b1;
          if (blk_full) begin
            after_d   = req_i.payload.end_of_message ? AFT_PAD : AFT_IDLE;
            pad_pos_d = '0;
            rnd_d     = '0;
            work_d    = '{a: h_q[0], b: h_q[1], c: h_q[2], d: h_q[3], e: h_q[4]};
          end else begin
            pad_pos_d = req_i.payload.byte_valid ? count_q[5:0] + 6'd1 : count_q[5:0];
          end
        end
      end
      ST_ROUND: begin
        ctrl.shift = 1'b1;
        work_d     = work_rnd;
        rnd_d      = rnd_q + 7'd1;
      end
      ST_FOLD: begin
        h_d[0] = h_q[0] + work_q.a;
        h_d[1] = h_q[1] + work_q.b;
        h_d[2] = h_q[2] + work_q.c;
        h_d[3] = h_q[3] + work_q.d;
        h_d[4] = h_q[4] + work_q.e;
        // a padding block after a fold always starts at 0 and ends with the length;
        // pad_first stays set when the message ended on a full block
        len_blk_d   = 1'b1;
        pad_pos_d   = '0;
        idx_d       = '0;
      end
      ST_PAD: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wr_idx = pad_pos_q;
        if (pad_first_q) begin
          ctrl.wr_byte = PadByte;
        end else if (len_blk_q && pad_pos_q >= LenPos) begin
          ctrl.wr_byte = len_bits[{~pad_pos_q[2:0], 3'b000} +: 8];
        end else begin
          ctrl.wr_byte = '0;
        end
        pad_first_d = 1'b0;
        len_blk_d   = len_here;
        pad_pos_d   = pad_pos_q + 6'd1;
        if (pad_pos_q == BlkLast) begin
          after_d = len_here ? AFT_EMIT : AFT_PAD;
          rnd_d   = '0;
          work_d  = '{a: h_q[0], b: h_q[1], c: h_q[2], d: h_q[3], e: h_q[4]};
        end
      end
      ST_EMIT: begin
        if (dig_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == WordLast) begin
            h_d     = '{H0Init, H1Init, H2Init, H3Init, H4Init};
            count_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      after_q     <= AFT_IDLE;
      h_q         <= '{H0Init, H1Init, H2Init, H3Init, H4Init};
      count_q     <= '0;
      rnd_q       <= '0;
      pad_pos_q   <= '0;
      pad_first_q <= 1'b0;
      len_blk_q   <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      after_q     <= after_d;
      h_q         <= h_d;
      count_q     <= count_d;
      rnd_q       <= rnd_d;
      pad_pos_q   <= pad_pos_d;
      pad_first_q <= pad_first_d;
      len_blk_q   <= len_blk_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && dig_o.valid))
    else $error("request taken while digest pending");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (rnd_q <= RoundLast))
    else $error("round counter out of range");

  a_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dig_acc && dig_o.payload.digest_last) |=>
      (state_q == ST_IDLE && count_q == '0 && h_q[0] == H0Init))
    else $error("engine not reinitialized after digest");

  a_pad_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAD && pad_pos_q == BlkLast) |=> (state_q == ST_ROUND && rnd_q == '0))
    else $error("padding block not compressed");

endmodule

/* rtl/core/sha1_sched.sv */
module sha1_sched
  import sha1_pkg::*;
(
  input  logic        clk_i,
  input  sched_ctrl_t ctrl_i,
  output logic [31:0] w_o
);

  // win_q[0] holds W[t]; each shift appends W[t+16]
  logic [31:0] win_q [WinWords];
  logic [31:0] w_next;

  assign w_next = rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);
  assign w_o    = win_q[0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      for (int i = 0; i < WinWords - 1; i++) begin
        win_q[i] <= win_q[i + 1];
      end
      win_q[WinWords - 1] <= w_next;
    end else if (ctrl_i.wr_en) begin
      // byte 0 of a word sits in bits 31:24
      win_q[ctrl_i.wr_idx[5:2]][{~ctrl_i.wr_idx[1:0], 3'b000} +: 8] <= ctrl_i.wr_byte;
    end
  end

endmodule

/* rtl/core/sha1_round.sv */
module sha1_round
  import sha1_pkg::*;
(
  input  work_t       work_i,
  input  logic [31:0] w_i,
  input  logic [6:0]  rnd_i,
  output work_t       work_o
);

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (rnd_i < 7'd20) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      k = K0;
    end else if (rnd_i < 7'd40) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = K1;
    end else if (rnd_i < 7'd60) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
      k = K2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = K3;
    end
  end

  always_comb begin
    work_o.a = rotl(work_i.a, 5) + f + work_i.e + k + w_i;
    work_o.b = work_i.a;
    work_o.c = rotl(work_i.b, 30);
    work_o.d = work_i.c;
    work_o.e = work_i.d;
  end

endmodule

/* dv/sha1_hash_engine_core_tb.sv */
module sha1_hash_engine_core_tb;
  import sha1_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    req_t req;
    logic drain;  // hold this request until no digest word is outstanding
  } pend_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  sha1_stream_if #(.payload_t(req_t)) req_if ();
  sha1_stream_if #(.payload_t(dig_t)) dig_if ();

  sha1_hash_engine_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .dig_o  (dig_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  pend_t pend_q[$];
  dig_t  digest_q[$];
  int    mismatches = 0;
  int    words_seen = 0;
  int    sent_items = 0;

  // hash state as seen by the checker
  logic [31:0] hash_st [5] = '{H0Init, H1Init, H2Init, H3Init, H4Init};
  logic [7:0]  blk_buf [64];
  logic [60:0] byte_cnt = '0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int pause_len(input bit calm);
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic void enqueue_req(input pend_t p);
    pend_q.insert(pend_q.size(), p);
  endfunction

  task automatic sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wt, tmp;
    int t;
    for (t = 0; t < 16; t++) begin
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    end
    a = hash_st[0];
    b = hash_st[1];
    c = hash_st[2];
    d = hash_st[3];
    e = hash_st[4];
    for (t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        tmp = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
        wt = {tmp[30:0], tmp[31]};
        w[t % 16] = wt;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      tmp = {a[26:0], a[31:27]} + f + e + k + wt;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    hash_st[0] += a;
    hash_st[1] += b;
    hash_st[2] += c;
    hash_st[3] += d;
    hash_st[4] += e;
  endtask

  // one accepted request: append its byte, and on end of message pad,
  // finish and queue the five digest words
  task automatic sha1_absorb(input req_t r);
    int fill;
    logic [63:0] bit_len;
    if (r.byte_valid) begin
      blk_buf[byte_cnt[5:0]] = r.data_byte;
      byte_cnt = byte_cnt + 1'b1;
      if (byte_cnt[5:0] == 6'd0) sha1_compress();
    end
    if (r.end_of_message) begin
      fill = byte_cnt[5:0];
      blk_buf[fill] = PadByte;
      fill++;
      if (fill > 56) begin
        while (fill < 64) begin
          blk_buf[fill] = 8'h00;
          fill++;
        end
        sha1_compress();
        fill = 0;
      end
      while (fill < 56) begin
        blk_buf[fill] = 8'h00;
        fill++;
      end
      bit_len = {byte_cnt, 3'b000};
      for (int i = 0; i < 8; i++) blk_buf[56 + i] = bit_len[63 - 8*i -: 8];
      sha1_compress();
      for (int i = 0; i < 5; i++) digest_q.insert(digest_q.size(), {hash_st[i], i == 4});
      hash_st = '{H0Init, H1Init, H2Init, H3Init, H4Init};
      byte_cnt = '0;
    end
  endtask

  // random message; idle requests sprinkled in, end mark on the last byte
  // or on a request of its own
  task automatic queue_message(input int len, input bit drain_first);
    bit split, hold;
    hold = drain_first;
    split = (len == 0) || ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        enqueue_req({8'($urandom_range(0, 255)), 1'b0, 1'b0, hold});
        hold = 1'b0;
      end
      enqueue_req({8'($urandom_range(0, 255)), 1'b1, !split && (i == len - 1), hold});
      hold = 1'b0;
    end
    if (split) enqueue_req({8'($urandom_range(0, 255)), 1'b0, 1'b1, hold});
    sent_items += len + split;
  endtask

  // request driver
  int send_gap;
  bit send_calm;
  always @(posedge clk_i or negedge rst_ni) begin : drv
    pend_t nxt;
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      send_gap       <= 0;
      send_calm      <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) sha1_absorb(req_if.payload);
      if (!req_if.valid || req_if.ready) begin
        if (send_gap != 0) begin
          req_if.valid <= 1'b0;
          send_gap     <= send_gap - 1;
        end else if (pend_q.size() != 0 && !(pend_q[0].drain && digest_q.size() != 0)) begin
          nxt = pend_q.pop_front();
          req_if.valid   <= 1'b1;
          req_if.payload <= nxt.req;
          send_gap       <= pause_len(send_calm);
          if ($urandom_range(0, 15) == 0) send_calm <= ~send_calm;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // digest monitor
  int recv_gap;
  bit recv_calm;
  always @(posedge clk_i or negedge rst_ni) begin : mon
    dig_t want;
    int n;
    if (!rst_ni) begin
      dig_if.ready <= 1'b0;
      recv_gap     <= 0;
      recv_calm    <= 1'b0;
    end else if (dig_if.valid && dig_if.ready) begin
      if (digest_q.size() == 0) begin
        report_mismatch($sformatf("digest word %h with no message pending",
                                  dig_if.payload.digest_word));
      end else begin
        want = digest_q.pop_front();
        if (dig_if.payload.digest_word !== want.digest_word)
          report_mismatch($sformatf("word %0d: digest_word %h, predicted %h", words_seen,
                                    dig_if.payload.digest_word, want.digest_word));
        if (dig_if.payload.digest_last !== want.digest_last)
          report_mismatch($sformatf("word %0d: digest_last %b, predicted %b", words_seen,
                                    dig_if.payload.digest_last, want.digest_last));
      end
      words_seen++;
      n = pause_len(recv_calm);
      if ($urandom_range(0, 15) == 0) recv_calm <= ~recv_calm;
      if (n == 0) begin
        dig_if.ready <= 1'b1;
      end else begin
        dig_if.ready <= 1'b0;
        recv_gap     <= n - 1;
      end
    end else if (!dig_if.ready) begin
      if (recv_gap == 0) dig_if.ready <= 1'b1;
      else recv_gap <= recv_gap - 1;
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int len;
    bit first;
    rst_ni <= 1'b0;

    // directed: dropped request, empty message, "abc", end mark without a byte,
    // byte extremes, idle request inside a message, empty end carrying data
    enqueue_req({8'hA5, 1'b0, 1'b0, 1'b0});
    enqueue_req({8'h00, 1'b0, 1'b1, 1'b0});
    enqueue_req({8'h61, 1'b1, 1'b0, 1'b0});
    enqueue_req({8'h62, 1'b1, 1'b0, 1'b0});
    enqueue_req({8'h63, 1'b1, 1'b1, 1'b0});
    enqueue_req({8'hFF, 1'b1, 1'b0, 1'b0});
    enqueue_req({8'h00, 1'b0, 1'b1, 1'b0});
    enqueue_req({8'h00, 1'b1, 1'b1, 1'b0});
    enqueue_req({8'h55, 1'b1, 1'b0, 1'b0});
    enqueue_req({8'hAA, 1'b0, 1'b0, 1'b0});
    enqueue_req({8'h0F, 1'b1, 1'b0, 1'b0});
    enqueue_req({8'hF0, 1'b1, 1'b1, 1'b0});
    enqueue_req({8'hFF, 1'b0, 1'b1, 1'b0});

    // random messages; some sit on the padding boundaries (one or two tail blocks)
    first = 1'b1;
    while (sent_items < 200) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 5))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          default: len = 65;
        endcase
      end else begin
        len = $urandom_range(0, 16);
      end
      queue_message(len, first || ($urandom_range(0, 5) == 0));
      first = 1'b0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pend_q.size() != 0 || req_if.valid) @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
